// File: hdl/urt_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic range timer package
// Shared widths, constants and status types for the range timer pipeline.
// ----------------------------------------------------------------------------
package urt_pkg;

    // Field widths fixed by the register map and the result format.
    localparam int PERIOD_CFG_W = 24;
    localparam int HALF_CFG_W   = 8;
    localparam int PULSE_CFG_W  = 4;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_ADDR_W   = 2;
    localparam int DIST_W       = 14;
    localparam int DIGIT_W      = 4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_MEASURE_PERIOD    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BURST_HALF_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BURST_PULSES      = 2'd2;

    // Configuration reset values.
    localparam logic [PERIOD_CFG_W-1:0] MEASURE_PERIOD_RST    = 24'd184320;
    localparam logic [HALF_CFG_W-1:0]   BURST_HALF_PERIOD_RST = 8'd12;
    localparam logic [PULSE_CFG_W-1:0]  BURST_PULSES_RST      = 4'd8;

    // Distance scaling: distance = floor(count * 17 / 1000).
    localparam int SCALE_NUM_SHIFT = 4;     // 17 = 16 + 1
    localparam int SCALE_DEN       = 1000;

    // Special distance values.
    localparam logic [DIST_W-1:0] NO_ECHO_DIST   = 14'd9999;
    localparam logic [DIST_W-1:0] MAX_VALID_DIST = 14'd9998;

    // Reciprocals for splitting a 14-bit distance into decimal digits.
    localparam logic [15:0] RECIP_10    = 16'd52429;   // 2^19 / 10, rounded up
    localparam int          SHIFT_10    = 19;
    localparam logic [14:0] RECIP_100   = 15'd20972;   // 2^21 / 100, rounded up
    localparam int          SHIFT_100   = 21;
    localparam logic [14:0] RECIP_1000  = 15'd16778;   // 2^24 / 1000, rounded up
    localparam int          SHIFT_1000  = 24;

    // Status of one tick as it leaves the control stage.
    typedef struct packed {
        logic tx_drive;
        logic busy_res;
        logic result_ready;
        logic timeout;
    } urt_flags_t;

    // Status of one tick once the held result has been updated.
    typedef struct packed {
        logic tx_drive;
        logic busy_res;
        logic result_ready;
        logic no_echo;
    } urt_status_t;

endpackage

// File: hdl/urt_ctrl.sv
// ----------------------------------------------------------------------------
// Range timer control stage
// Holds the configuration registers, the period counter and the burst and
// listen sequencer. One tick is taken per transfer and its status is
// registered for the distance stages.
// ----------------------------------------------------------------------------
module urt_ctrl
    import urt_pkg::*;
#(
    parameter int ECHO_COUNT_BITS = 16,
    parameter int PERIOD_BITS     = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      echo_level,
    output logic                      out_valid,
    input  logic                      out_ready,
    output urt_flags_t                out_flags,
    output logic [ECHO_COUNT_BITS+SCALE_NUM_SHIFT:0] out_scaled
);

    localparam int YW = ECHO_COUNT_BITS + SCALE_NUM_SHIFT + 1;
    localparam int CW = (PERIOD_BITS + 1 > PERIOD_CFG_W) ? PERIOD_BITS + 1 : PERIOD_CFG_W;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_BURST  = 2'd1;
    localparam logic [1:0] PH_LISTEN = 2'd2;

    // Configuration registers
    logic [PERIOD_CFG_W-1:0] measure_period_reg;
    logic [HALF_CFG_W-1:0]   burst_half_period_reg;
    logic [PULSE_CFG_W-1:0]  burst_pulses_reg;

    // Sequencer state
    logic [1:0]                 phase_reg, phase_next;
    logic [PERIOD_BITS-1:0]     period_count_reg, period_count_next;
    logic                       request_pending_reg, request_pending_next;
    logic [HALF_CFG_W-1:0]      half_count_reg, half_count_next;
    logic [PULSE_CFG_W-1:0]     pulse_count_reg, pulse_count_next;
    logic                       tx_level_reg, tx_level_next;
    logic [ECHO_COUNT_BITS-1:0] echo_count_reg, echo_count_next;

    // Output stage
    logic          p1_valid_reg;
    urt_flags_t    p1_flags_reg;
    logic [YW-1:0] p1_scaled_reg;

    logic                   accept;
    logic [CW-1:0]          period_inc;
    logic                   period_wrap;
    logic [HALF_CFG_W-1:0]  half_limit;
    logic [PULSE_CFG_W-1:0] pulse_limit;
    logic [PULSE_CFG_W-1:0] pulse_inc;
    logic [YW-1:0]          scaled_count;
    logic                   ready_now;
    logic                   timeout_now;

    assign in_ready = !p1_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Period counter wrap test; a zero period behaves as one.
    assign period_inc  = CW'(period_count_reg) + CW'(1);
    assign period_wrap = (&period_count_reg) || (period_inc >= CW'(measure_period_reg));

    assign half_limit  = (burst_half_period_reg == '0) ? HALF_CFG_W'(1) : burst_half_period_reg;
    assign pulse_limit = (burst_pulses_reg == '0) ? PULSE_CFG_W'(1) : burst_pulses_reg;
    assign pulse_inc   = pulse_count_reg + PULSE_CFG_W'(1);

    // count * 17 by shift and add, ready for the divide by 1000.
    assign scaled_count = (YW'(echo_count_reg) << SCALE_NUM_SHIFT) + YW'(echo_count_reg);

    // Next state for one tick.
    always_comb begin
        phase_next           = phase_reg;
        period_count_next    = period_count_reg;
        request_pending_next = request_pending_reg;
        half_count_next      = half_count_reg;
        pulse_count_next     = pulse_count_reg;
        tx_level_next        = tx_level_reg;
        echo_count_next      = echo_count_reg;
        ready_now            = 1'b0;
        timeout_now          = 1'b0;

        if (period_wrap) begin
            period_count_next    = '0;
            request_pending_next = 1'b1;
        end else begin
            period_count_next = period_inc[PERIOD_BITS-1:0];
        end

        unique case (phase_reg)
            PH_BURST: begin
                if (half_count_reg >= half_limit) begin
                    half_count_next = HALF_CFG_W'(1);
                    if (tx_level_reg) begin
                        tx_level_next = 1'b0;
                    end else begin
                        pulse_count_next = pulse_inc;
                        if (pulse_inc >= pulse_limit) begin
                            phase_next      = PH_LISTEN;
                            echo_count_next = '0;
                            half_count_next = '0;
                        end else begin
                            tx_level_next = 1'b1;
                        end
                    end
                end else begin
                    half_count_next = half_count_reg + HALF_CFG_W'(1);
                end
            end
            PH_LISTEN: begin
                if (!echo_level) begin
                    ready_now  = 1'b1;
                    phase_next = PH_IDLE;
                end else if (&echo_count_reg) begin
                    echo_count_next = '0;
                    ready_now       = 1'b1;
                    timeout_now     = 1'b1;
                    phase_next      = PH_IDLE;
                end else begin
                    echo_count_next = echo_count_reg + ECHO_COUNT_BITS'(1);
                end
            end
            default: begin
                // Idle and the unused code both wait for a request.
                phase_next = PH_IDLE;
                if (request_pending_next) begin
                    request_pending_next = 1'b0;
                    phase_next           = PH_BURST;
                    tx_level_next        = 1'b1;
                    half_count_next      = HALF_CFG_W'(1);
                    pulse_count_next     = '0;
                end
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measure_period_reg    <= MEASURE_PERIOD_RST;
            burst_half_period_reg <= BURST_HALF_PERIOD_RST;
            burst_pulses_reg      <= BURST_PULSES_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MEASURE_PERIOD:    measure_period_reg    <= cfg_wdata;
                CFG_BURST_HALF_PERIOD: burst_half_period_reg <= cfg_wdata[HALF_CFG_W-1:0];
                CFG_BURST_PULSES:      burst_pulses_reg      <= cfg_wdata[PULSE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            period_count_reg    <= '0;
            request_pending_reg <= 1'b0;
            half_count_reg      <= '0;
            pulse_count_reg     <= '0;
            tx_level_reg        <= 1'b0;
            echo_count_reg      <= '0;
        end else if (accept) begin
            phase_reg           <= phase_next;
            period_count_reg    <= period_count_next;
            request_pending_reg <= request_pending_next;
            half_count_reg      <= half_count_next;
            pulse_count_reg     <= pulse_count_next;
            tx_level_reg        <= tx_level_next;
            echo_count_reg      <= echo_count_next;
        end
    end

    // Registered tick status toward the distance stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_flags_reg.tx_drive     <= tx_level_next;
            p1_flags_reg.busy_res     <= (phase_next != PH_IDLE);
            p1_flags_reg.result_ready <= ready_now;
            p1_flags_reg.timeout      <= timeout_now;
            p1_scaled_reg             <= scaled_count;
        end
    end

    assign out_valid  = p1_valid_reg;
    assign out_flags  = p1_flags_reg;
    assign out_scaled = p1_scaled_reg;

    // The transmitter is driven only during a burst.
    a_tx_only_in_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_BURST) |-> !tx_level_reg)
        else $error("transmitter high outside a burst");

    // Within a burst the half counter never rests at zero.
    a_half_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BURST) |-> (half_count_reg != '0))
        else $error("half counter zero during a burst");

endmodule

// File: hdl/urt_dist.sv
// ----------------------------------------------------------------------------
// Range timer distance stages
// Divides the scaled echo count by 1000 with a reciprocal multiply and a
// remainder correction, and holds the latest distance and no-echo flag.
// ----------------------------------------------------------------------------
module urt_dist
    import urt_pkg::*;
#(
    parameter int ECHO_COUNT_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  urt_flags_t                in_flags,
    input  logic [ECHO_COUNT_BITS+SCALE_NUM_SHIFT:0] in_scaled,
    output logic                      out_valid,
    input  logic                      out_ready,
    output urt_status_t               out_status,
    output logic [DIST_W-1:0]         out_dist
);

    localparam int YW = ECHO_COUNT_BITS + SCALE_NUM_SHIFT + 1;
    localparam int QW = YW - 9;
    localparam int DW = (QW > DIST_W) ? QW : DIST_W;
    localparam longint unsigned RECIP = (64'd1 << YW) / SCALE_DEN;

    logic s2_load, s3_load;

    // Stage 2: quotient estimate, at most one below the true quotient.
    logic          s2_valid_reg;
    urt_flags_t    s2_flags_reg;
    logic [YW-1:0] s2_scaled_reg;
    logic [QW-1:0] s2_qest_reg;
    logic [YW+QW-1:0] product;

    // Stage 3: corrected distance and the held result.
    logic               s3_valid_reg;
    urt_flags_t         s3_flags_reg;
    logic [DIST_W-1:0]  held_dist_reg;
    logic               held_ne_reg;

    logic [YW-1:0] remainder;
    logic [QW-1:0] quotient;
    logic [DW-1:0] quotient_ext;
    logic [DIST_W-1:0] dist_new;

    assign s3_load  = !s3_valid_reg || out_ready;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign in_ready = s2_load;

    assign product = (YW+QW)'(in_scaled) * (YW+QW)'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_load) begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load && in_valid) begin
            s2_flags_reg  <= in_flags;
            s2_scaled_reg <= in_scaled;
            s2_qest_reg   <= product[YW+QW-1:YW];
        end
    end

    // Remainder check fixes the estimate, then saturate or mark no echo.
    assign remainder    = s2_scaled_reg - YW'(s2_qest_reg) * YW'(SCALE_DEN);
    assign quotient     = s2_qest_reg + QW'(remainder >= YW'(SCALE_DEN));
    assign quotient_ext = DW'(quotient);

    always_comb begin
        priority if (s2_flags_reg.timeout) begin
            dist_new = NO_ECHO_DIST;
        end else if (quotient_ext > DW'(MAX_VALID_DIST)) begin
            dist_new = MAX_VALID_DIST;
        end else begin
            dist_new = quotient_ext[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            held_dist_reg <= '0;
            held_ne_reg   <= 1'b0;
        end else if (s3_load) begin
            s3_valid_reg <= s2_valid_reg;
            if (s2_valid_reg && s2_flags_reg.result_ready) begin
                held_dist_reg <= dist_new;
                held_ne_reg   <= s2_flags_reg.timeout;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_load && s2_valid_reg) begin
            s3_flags_reg <= s2_flags_reg;
        end
    end

    assign out_valid               = s3_valid_reg;
    assign out_status.tx_drive     = s3_flags_reg.tx_drive;
    assign out_status.busy_res     = s3_flags_reg.busy_res;
    assign out_status.result_ready = s3_flags_reg.result_ready;
    assign out_status.no_echo      = held_ne_reg;
    assign out_dist                = held_dist_reg;

    // A held no-echo result always carries the no-echo distance.
    a_no_echo_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        held_ne_reg |-> (held_dist_reg == NO_ECHO_DIST))
        else $error("no-echo flag held with a measured distance");

endmodule

// File: hdl/urt_digits.sv
// ----------------------------------------------------------------------------
// Range timer digit stages
// Splits the held distance into hundreds, tens and ones digits with
// reciprocal multiplies and drives the registered result channel.
// ----------------------------------------------------------------------------
module urt_digits
    import urt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  urt_status_t         in_status,
    input  logic [DIST_W-1:0]   in_dist,
    output logic                out_valid,
    input  logic                out_ready,
    output urt_status_t         out_status,
    output logic [DIST_W-1:0]   out_dist,
    output logic [DIGIT_W-1:0]  out_hundreds,
    output logic [DIGIT_W-1:0]  out_tens,
    output logic [DIGIT_W-1:0]  out_ones
);

    logic s4_load, s5_load;

    // Stage 4: quotients by 10, 100 and 1000.
    logic              s4_valid_reg;
    urt_status_t       s4_status_reg;
    logic [DIST_W-1:0] s4_dist_reg;
    logic [10:0]       s4_q10_reg;
    logic [7:0]        s4_q100_reg;
    logic [4:0]        s4_q1000_reg;

    logic [29:0] prod10;
    logic [28:0] prod100;
    logic [28:0] prod1000;

    // Stage 5: result register.
    logic               s5_valid_reg;
    urt_status_t        s5_status_reg;
    logic [DIST_W-1:0]  s5_dist_reg;
    logic [DIGIT_W-1:0] s5_hundreds_reg;
    logic [DIGIT_W-1:0] s5_tens_reg;
    logic [DIGIT_W-1:0] s5_ones_reg;

    logic [DIST_W-1:0] ones_diff;
    logic [10:0]       tens_diff;
    logic [7:0]        hundreds_diff;

    assign s5_load  = !s5_valid_reg || out_ready;
    assign s4_load  = !s4_valid_reg || s5_load;
    assign in_ready = s4_load;

    assign prod10   = 30'(in_dist) * 30'(RECIP_10);
    assign prod100  = 29'(in_dist) * 29'(RECIP_100);
    assign prod1000 = 29'(in_dist) * 29'(RECIP_1000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_load) begin
            s4_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_load && in_valid) begin
            s4_status_reg <= in_status;
            s4_dist_reg   <= in_dist;
            s4_q10_reg    <= prod10[29:SHIFT_10];
            s4_q100_reg   <= prod100[28:SHIFT_100];
            s4_q1000_reg  <= prod1000[28:SHIFT_1000];
        end
    end

    // Each digit is a quotient less ten times the next quotient.
    assign ones_diff     = s4_dist_reg - DIST_W'(s4_q10_reg) * DIST_W'(10);
    assign tens_diff     = s4_q10_reg - 11'(s4_q100_reg) * 11'(10);
    assign hundreds_diff = s4_q100_reg - 8'(s4_q1000_reg) * 8'(10);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_load) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_load && s4_valid_reg) begin
            s5_status_reg   <= s4_status_reg;
            s5_dist_reg     <= s4_dist_reg;
            s5_hundreds_reg <= hundreds_diff[DIGIT_W-1:0];
            s5_tens_reg     <= tens_diff[DIGIT_W-1:0];
            s5_ones_reg     <= ones_diff[DIGIT_W-1:0];
        end
    end

    assign out_valid    = s5_valid_reg;
    assign out_status   = s5_status_reg;
    assign out_dist     = s5_dist_reg;
    assign out_hundreds = s5_hundreds_reg;
    assign out_tens     = s5_tens_reg;
    assign out_ones     = s5_ones_reg;

    // Every digit on the result channel is a decimal digit.
    a_digits_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        s5_valid_reg |-> (s5_hundreds_reg < 4'd10 && s5_tens_reg < 4'd10 &&
                          s5_ones_reg < 4'd10))
        else $error("digit out of decimal range");

endmodule

// File: hdl/ultrasonic_range_timer.sv
// A tick goes through the control, estimate, held-result, quotient and result registers.
// Throughput: one tick per cycle; the control stage takes a tick every cycle
// the result pipeline has room, stalling only when all five stages are full.
// Reset clears the sequencer, the counters, the held distance and the
// pipeline, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Ultrasonic range timer
// Burst transmitter and echo timer with a latched distance in centimeters
// and its decimal digits, one result per timer tick.
// ----------------------------------------------------------------------------
module ultrasonic_range_timer
    import urt_pkg::*;
#(
    parameter int ECHO_COUNT_BITS = 16,
    parameter int PERIOD_BITS     = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Tick input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] echo_level
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] tx_drive, [1] busy_res, [2] result_ready, [16:3] distance_cm,
    // [20:17] digit_hundreds, [24:21] digit_tens, [28:25] digit_ones
    output logic [31:0]           m_tdata,
    output logic                  m_tuser    // [0] no_echo
);

    localparam int YW = ECHO_COUNT_BITS + SCALE_NUM_SHIFT + 1;

    logic          c2d_valid, c2d_ready;
    urt_flags_t    c2d_flags;
    logic [YW-1:0] c2d_scaled;

    logic              d2g_valid, d2g_ready;
    urt_status_t       d2g_status;
    logic [DIST_W-1:0] d2g_dist;

    urt_status_t        res_status;
    logic [DIST_W-1:0]  res_dist;
    logic [DIGIT_W-1:0] res_hundreds;
    logic [DIGIT_W-1:0] res_tens;
    logic [DIGIT_W-1:0] res_ones;

    // Sequencer and tick capture
    urt_ctrl #(
        .ECHO_COUNT_BITS (ECHO_COUNT_BITS),
        .PERIOD_BITS     (PERIOD_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .echo_level (s_tdata[0]),
        .out_valid  (c2d_valid),
        .out_ready  (c2d_ready),
        .out_flags  (c2d_flags),
        .out_scaled (c2d_scaled)
    );

    // Distance division and held result
    urt_dist #(
        .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (c2d_valid),
        .in_ready   (c2d_ready),
        .in_flags   (c2d_flags),
        .in_scaled  (c2d_scaled),
        .out_valid  (d2g_valid),
        .out_ready  (d2g_ready),
        .out_status (d2g_status),
        .out_dist   (d2g_dist)
    );

    // Decimal digits and result register
    urt_digits u_digits (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (d2g_valid),
        .in_ready     (d2g_ready),
        .in_status    (d2g_status),
        .in_dist      (d2g_dist),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (res_status),
        .out_dist     (res_dist),
        .out_hundreds (res_hundreds),
        .out_tens     (res_tens),
        .out_ones     (res_ones)
    );

    // Result packing, highest field first.
    assign m_tdata = {3'b000, res_ones, res_tens, res_hundreds, res_dist,
                      res_status.result_ready, res_status.busy_res, res_status.tx_drive};
    assign m_tuser = res_status.no_echo;

endmodule
